// ===== hdl/alrc_pkg.sv =====
// ----------------------------------------------------------------------------
// alrc_pkg
// Shared types and constants for the left-to-right calculator core.
// ----------------------------------------------------------------------------
package alrc_pkg;

  // Default accumulator width and fixed result port width
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_W           = 32;

  // Character codes that the parser recognizes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Operator codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Line status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_MISSING = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_EMIT
  } state_t;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_ctl_t;

endpackage

// ===== hdl/ascii_left_to_right_calculator_core.sv =====
// ----------------------------------------------------------------------------
// ascii_left_to_right_calculator_core
// Evaluates a line of ASCII characters left to right on a signed accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry char_code and end_of_line on in_valid/in_stall.
//   Characters other than digits and + - * / are dropped. Each end-of-line
//   request yields exactly one result request (value, status) on
//   out_valid/out_stall; other requests yield none.
//   Timing: a digit, a dropped character, or an operator that closes an add
//   or subtract leaves the core ready for the next request. An operator that
//   closes a multiply or a divide runs the shared bit-serial unit, one
//   quotient or multiplier bit per cycle, and no request is taken until
//   the unit is done.
//   An end-of-line request shows its result in the next cycle, or from the
//   emit state after the unit run when it closes a multiply or divide.
//   The result sits in an output register; further characters are taken
//   while it waits. An end-of-line request is also held off while that
//   register is full and stalled.
//   Reset clears the line state and drops any pending result.
// ----------------------------------------------------------------------------
module ascii_left_to_right_calculator_core #(
  parameter int VALUE_WIDTH = alrc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         char_code,
  input  logic                               end_of_line,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [alrc_pkg::OUT_W-1:0]  value,
  output logic [1:0]                         status
);

  localparam int OW = alrc_pkg::OUT_W;

  // Line state
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic [VALUE_WIDTH-1:0] operand, operand_next;
  alrc_pkg::op_t          pend_op, pend_op_next;
  logic                   op_pend, op_pend_next;
  logic                   digit_after, digit_after_next;
  logic                   nonempty, nonempty_next;
  alrc_pkg::status_t      err, err_next;
  alrc_pkg::state_t       state, state_next;
  alrc_pkg::op_t          new_op, new_op_next;
  logic                   saved_eol, saved_eol_next;

  // Output register
  logic                   out_valid_next;
  logic [OW-1:0]          value_reg, value_next;
  alrc_pkg::status_t      status_reg, status_next;

  // Decode and helpers
  logic                   accept;
  logic                   out_free;
  logic                   is_digit;
  logic                   is_op;
  alrc_pkg::op_t          char_op;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] x10_in;
  logic [VALUE_WIDTH-1:0] x10_out;
  logic [VALUE_WIDTH-1:0] addsub;
  logic [OW+VALUE_WIDTH-1:0] acc_wide;

  alrc_pkg::unit_ctl_t    unit_ctl;
  logic                   unit_done;
  logic [VALUE_WIDTH-1:0] unit_result;

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != alrc_pkg::S_IDLE) || (end_of_line && !out_free);
  assign accept   = in_valid && !in_stall;

  assign value  = value_reg;
  assign status = status_reg;

  // Character decode
  assign is_digit = char_code inside {[alrc_pkg::CH_ZERO : alrc_pkg::CH_NINE]};
  assign digit    = 4'(char_code - alrc_pkg::CH_ZERO);

  always_comb begin
    is_op   = 1'b1;
    char_op = alrc_pkg::OP_ADD;
    case (char_code)
      alrc_pkg::CH_PLUS:  char_op = alrc_pkg::OP_ADD;
      alrc_pkg::CH_MINUS: char_op = alrc_pkg::OP_SUB;
      alrc_pkg::CH_STAR:  char_op = alrc_pkg::OP_MUL;
      alrc_pkg::CH_SLASH: char_op = alrc_pkg::OP_DIV;
      default:            is_op   = 1'b0;
    endcase
  end

  // Decimal accumulate: x*10 + d as two shifted adds
  assign x10_in  = op_pend ? operand : acc;
  assign x10_out = {x10_in[VALUE_WIDTH-4:0], 3'b000} + {x10_in[VALUE_WIDTH-2:0], 1'b0}
                   + {{(VALUE_WIDTH-4){1'b0}}, digit};

  // Add or subtract the pending operand
  assign addsub = (pend_op == alrc_pkg::OP_SUB) ? (acc - operand) : (acc + operand);

  // Low result bits, zero padded when the accumulator is narrow
  assign acc_wide = {{OW{1'b0}}, acc};

  alrc_arith_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .ctl    (unit_ctl),
    .a      (acc),
    .b      (operand),
    .done   (unit_done),
    .result (unit_result)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      alrc_pkg::S_IDLE: begin
        if (unit_ctl.start) begin
          state_next = alrc_pkg::S_BUSY;
        end
      end
      alrc_pkg::S_BUSY: begin
        if (unit_done) begin
          state_next = saved_eol ? alrc_pkg::S_EMIT : alrc_pkg::S_IDLE;
        end
      end
      alrc_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = alrc_pkg::S_IDLE;
        end
      end
      default: state_next = alrc_pkg::S_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    logic              clear;
    logic              load_out;
    logic              set_op;
    alrc_pkg::status_t st;
    logic [VALUE_WIDTH-1:0] fin;

    acc_next         = acc;
    operand_next     = operand;
    pend_op_next     = pend_op;
    op_pend_next     = op_pend;
    digit_after_next = digit_after;
    nonempty_next    = nonempty;
    err_next         = err;
    new_op_next      = new_op;
    saved_eol_next   = saved_eol;
    out_valid_next   = out_valid && out_stall;
    value_next       = value_reg;
    status_next      = status_reg;
    unit_ctl.start   = 1'b0;
    unit_ctl.is_div  = (pend_op == alrc_pkg::OP_DIV);
    clear            = 1'b0;
    load_out         = 1'b0;
    set_op           = 1'b0;
    st               = err;
    fin              = acc;

    case (state)
      alrc_pkg::S_IDLE: begin
        if (accept && end_of_line) begin
          // Close the line
          if (st == alrc_pkg::ST_OK) begin
            if (!nonempty) begin
              st = alrc_pkg::ST_EMPTY;
            end else if (op_pend && !digit_after) begin
              st = alrc_pkg::ST_MISSING;
            end else if (op_pend) begin
              case (pend_op)
                alrc_pkg::OP_ADD, alrc_pkg::OP_SUB: fin = addsub;
                alrc_pkg::OP_MUL: unit_ctl.start = 1'b1;
                default: begin
                  if (operand == '0) begin
                    st = alrc_pkg::ST_DIVZERO;
                  end else begin
                    unit_ctl.start = 1'b1;
                  end
                end
              endcase
            end
          end
          if (unit_ctl.start) begin
            saved_eol_next = 1'b1;
          end else begin
            load_out = 1'b1;
            clear    = 1'b1;
          end
        end else if (accept && is_digit) begin
          // Accumulate a digit
          nonempty_next = 1'b1;
          if (err == alrc_pkg::ST_OK) begin
            if (op_pend) begin
              operand_next     = x10_out;
              digit_after_next = 1'b1;
            end else begin
              acc_next = x10_out;
            end
          end
        end else if (accept && is_op) begin
          // Close the operand and open a new operator
          nonempty_next = 1'b1;
          if (err == alrc_pkg::ST_OK) begin
            if (!op_pend) begin
              set_op = 1'b1;
            end else if (!digit_after) begin
              err_next = alrc_pkg::ST_MISSING;
            end else begin
              case (pend_op)
                alrc_pkg::OP_ADD, alrc_pkg::OP_SUB: begin
                  acc_next = addsub;
                  set_op   = 1'b1;
                end
                alrc_pkg::OP_MUL: unit_ctl.start = 1'b1;
                default: begin
                  if (operand == '0) begin
                    err_next = alrc_pkg::ST_DIVZERO;
                  end else begin
                    unit_ctl.start = 1'b1;
                  end
                end
              endcase
            end
            if (unit_ctl.start) begin
              saved_eol_next = 1'b0;
              new_op_next    = char_op;
            end
          end
        end
        if (set_op) begin
          pend_op_next = char_op;
        end
      end
      alrc_pkg::S_BUSY: begin
        // Take the unit result, then open the saved operator unless the line closes
        if (unit_done) begin
          acc_next = unit_result;
          if (!saved_eol) begin
            pend_op_next = new_op;
            set_op       = 1'b1;
          end
        end
      end
      alrc_pkg::S_EMIT: begin
        if (out_free) begin
          st       = alrc_pkg::ST_OK;
          load_out = 1'b1;
          clear    = 1'b1;
        end
      end
      default: ;
    endcase

    if (set_op) begin
      op_pend_next     = 1'b1;
      digit_after_next = 1'b0;
      operand_next     = '0;
    end

    if (load_out) begin
      out_valid_next = 1'b1;
      status_next    = st;
      if (state == alrc_pkg::S_EMIT) begin
        value_next = acc_wide[OW-1:0];
      end else begin
        value_next = (st == alrc_pkg::ST_OK) ?
                     OW'({{OW{1'b0}}, fin}) : '0;
      end
    end

    if (clear) begin
      acc_next         = '0;
      operand_next     = '0;
      pend_op_next     = alrc_pkg::OP_ADD;
      op_pend_next     = 1'b0;
      digit_after_next = 1'b0;
      nonempty_next    = 1'b0;
      err_next         = alrc_pkg::ST_OK;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= alrc_pkg::S_IDLE;
      out_valid   <= 1'b0;
      acc         <= '0;
      operand     <= '0;
      pend_op     <= alrc_pkg::OP_ADD;
      op_pend     <= 1'b0;
      digit_after <= 1'b0;
      nonempty    <= 1'b0;
      err         <= alrc_pkg::ST_OK;
      saved_eol   <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      acc         <= acc_next;
      operand     <= operand_next;
      pend_op     <= pend_op_next;
      op_pend     <= op_pend_next;
      digit_after <= digit_after_next;
      nonempty    <= nonempty_next;
      err         <= err_next;
      saved_eol   <= saved_eol_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    new_op     <= new_op_next;
    value_reg  <= value_next;
    status_reg <= status_next;
  end

endmodule

// ===== hdl/alrc_arith_unit.sv =====
// ----------------------------------------------------------------------------
// alrc_arith_unit
// Bit-serial multiply and signed divide sharing one adder; one bit per cycle.
// ----------------------------------------------------------------------------
module alrc_arith_unit #(
  parameter int VALUE_WIDTH = alrc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  alrc_pkg::unit_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0]  a,
  input  logic [VALUE_WIDTH-1:0]  b,
  output logic                    done,
  output logic [VALUE_WIDTH-1:0]  result
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic                   is_div;
  logic                   neg;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] y;
  logic [VALUE_WIDTH-1:0] r;

  logic [VALUE_WIDTH-1:0] t;
  logic [VALUE_WIDTH-1:0] opa;
  logic [VALUE_WIDTH-1:0] opb;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] mag_a;
  logic [VALUE_WIDTH-1:0] mag_b;

  // Shared adder: add multiplicand, or subtract divisor via inverted operand
  assign t   = {r[VALUE_WIDTH-2:0], y[VALUE_WIDTH-1]};
  assign opa = is_div ? t : r;
  assign opb = is_div ? ~x : x;
  assign sum = {1'b0, opa} + {1'b0, opb} + {{VALUE_WIDTH{1'b0}}, is_div};

  // Magnitudes of the operands for the divide
  assign mag_a = a[VALUE_WIDTH-1] ? -a : a;
  assign mag_b = b[VALUE_WIDTH-1] ? -b : b;

  assign done   = busy && (count == CW'(VALUE_WIDTH));
  assign result = is_div ? (neg ? -y : y) : r;

  // Control: load on start, count steps, drop busy when done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      count <= count + CW'(1);
    end
  end

  // Datapath: one multiplier or quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_div <= ctl.is_div;
      neg    <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
      r      <= '0;
      x      <= ctl.is_div ? mag_b : a;
      y      <= ctl.is_div ? mag_a : b;
    end else if (busy && !done) begin
      if (is_div) begin
        if (sum[VALUE_WIDTH]) begin
          r <= sum[VALUE_WIDTH-1:0];
          y <= {y[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          r <= t;
          y <= {y[VALUE_WIDTH-2:0], 1'b0};
        end
      end else begin
        if (y[0]) begin
          r <= sum[VALUE_WIDTH-1:0];
        end
        x <= {x[VALUE_WIDTH-2:0], 1'b0};
        y <= {1'b0, y[VALUE_WIDTH-1:1]};
      end
    end
  end

endmodule

// ===== sim/alrc_line_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alrc_line_checker
// Watches both channels of the calculator core, predicts the result of every
// closed line and compares each result request field by field.
// ----------------------------------------------------------------------------
module alrc_line_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       char_code,
  input  logic                             end_of_line,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [alrc_pkg::OUT_W-1:0] value,
  input  logic [1:0]                       status,
  output int                               fail_count,
  output int                               results_waiting
);

  typedef struct packed {
    logic signed [alrc_pkg::OUT_W-1:0] value;
    alrc_pkg::status_t                 status;
  } line_result_t;

  // Predicted results of closed lines, oldest first
  line_result_t expected_lines[$];

  // Predicted line state
  logic [31:0]       run_acc;
  logic [31:0]       run_opnd;
  alrc_pkg::op_t     open_op;
  logic              op_open;
  logic              opnd_seen;
  logic              line_seen;
  alrc_pkg::status_t line_err;

  // Scratch for one request
  alrc_pkg::op_t     new_op;
  logic              is_op;
  alrc_pkg::status_t line_status;
  line_result_t      entry;
  int                mismatches = 0;

  // Apply an operator to the accumulator; returns 0 on division by zero.
  // Division works on magnitudes so that the most negative value over
  // minus one wraps instead of trapping.
  function automatic bit apply_op(input alrc_pkg::op_t op, input logic [31:0] a,
                                  input logic [31:0] b, output logic [31:0] r);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    r = a;
    apply_op = 1'b1;
    case (op)
      alrc_pkg::OP_ADD: r = a + b;
      alrc_pkg::OP_SUB: r = a - b;
      alrc_pkg::OP_MUL: r = a * b;
      default: begin
        if (b == 32'd0) begin
          apply_op = 1'b0;
        end else begin
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          quo   = mag_a / mag_b;
          r     = (a[31] ^ b[31]) ? -quo : quo;
        end
      end
    endcase
  endfunction

  task clear_line_state();
    run_acc   = '0;
    run_opnd  = '0;
    open_op   = alrc_pkg::OP_ADD;
    op_open   = 1'b0;
    opnd_seen = 1'b0;
    line_seen = 1'b0;
    line_err  = alrc_pkg::ST_OK;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line_state();
      expected_lines.delete();
    end else begin
      // Advance the predicted line state on each accepted request
      if (in_valid && !in_stall) begin
        is_op = 1'b1;
        case (char_code)
          alrc_pkg::CH_PLUS:  new_op = alrc_pkg::OP_ADD;
          alrc_pkg::CH_MINUS: new_op = alrc_pkg::OP_SUB;
          alrc_pkg::CH_STAR:  new_op = alrc_pkg::OP_MUL;
          alrc_pkg::CH_SLASH: new_op = alrc_pkg::OP_DIV;
          default: begin
            new_op = alrc_pkg::OP_ADD;
            is_op  = 1'b0;
          end
        endcase

        if (end_of_line) begin
          // Close the line: first error wins, then empty, trailing operator,
          // and a division by zero in the last term
          line_status = line_err;
          if (line_status == alrc_pkg::ST_OK) begin
            if (!line_seen)
              line_status = alrc_pkg::ST_EMPTY;
            else if (op_open && !opnd_seen)
              line_status = alrc_pkg::ST_MISSING;
            else if (op_open && !apply_op(open_op, run_acc, run_opnd, run_acc))
              line_status = alrc_pkg::ST_DIVZERO;
          end
          entry.value  = (line_status == alrc_pkg::ST_OK) ? run_acc : '0;
          entry.status = line_status;
          expected_lines.push_back(entry);
          clear_line_state();
        end else if (char_code >= alrc_pkg::CH_ZERO && char_code <= alrc_pkg::CH_NINE) begin
          line_seen = 1'b1;
          if (line_err == alrc_pkg::ST_OK) begin
            if (op_open) begin
              run_opnd  = run_opnd * 32'd10 + 32'(char_code - alrc_pkg::CH_ZERO);
              opnd_seen = 1'b1;
            end else begin
              run_acc = run_acc * 32'd10 + 32'(char_code - alrc_pkg::CH_ZERO);
            end
          end
        end else if (is_op) begin
          line_seen = 1'b1;
          if (line_err == alrc_pkg::ST_OK) begin
            if (op_open && !opnd_seen) begin
              line_err = alrc_pkg::ST_MISSING;
            end else if (op_open &&
                         !apply_op(open_op, run_acc, run_opnd, run_acc)) begin
              line_err = alrc_pkg::ST_DIVZERO;
            end else begin
              open_op   = new_op;
              op_open   = 1'b1;
              opnd_seen = 1'b0;
              run_opnd  = '0;
            end
          end
        end
      end

      // Compare each accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result value %0d status %0d",
                     $realtime, value, status);
        end else begin
          entry = expected_lines.pop_front();
          if (value !== entry.value || status !== entry.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: expected value %0d status %0d,",
                        " got value %0d status %0d"},
                       $realtime, entry.value, entry.status, value, status);
          end
        end
      end
    end
    fail_count      <= mismatches;
    results_waiting <= expected_lines.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ASCII lines into the calculator core with random gaps and output
// stalls; a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam int         CYCLE_LIMIT = 600000;

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic end_of_line = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic signed [alrc_pkg::OUT_W-1:0] value;
  logic [1:0] status;

  int fail_count;
  int results_waiting;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_items     = 0;
  int cycles         = 0;

  ascii_left_to_right_calculator_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .end_of_line (end_of_line),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .status      (status)
  );

  alrc_line_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code       (char_code),
    .end_of_line     (end_of_line),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .value           (value),
    .status          (status),
    .fail_count      (fail_count),
    .results_waiting (results_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Guard against a hung core
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one request and hold it until accepted; valid stays high into the
  // next request unless a gap is drawn
  task automatic send_req(input logic [7:0] c, input logic e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    char_code   <= c;
    end_of_line <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // Send a line of text and close it; the closing request carries junk
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
    send_req(8'($urandom_range(255)), 1'b1);
  endtask

  // Sprinkle spaces and random bytes in front of a kept character
  task automatic send_with_noise(input logic [7:0] c);
    if ($urandom_range(99) < 8) send_req(CH_SPACE, 1'b0);
    if ($urandom_range(99) < 3) send_req(8'($urandom_range(255)), 1'b0);
    send_req(c, 1'b0);
  endtask

  // Send a number most significant digit first, now and then with a
  // leading zero
  task automatic send_number(input longint unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(alrc_pkg::CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(99) < 5) digits.push_front(alrc_pkg::CH_ZERO);
    foreach (digits[i]) send_with_noise(digits[i]);
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0:       return alrc_pkg::CH_PLUS;
      1:       return alrc_pkg::CH_MINUS;
      2:       return alrc_pkg::CH_STAR;
      default: return alrc_pkg::CH_SLASH;
    endcase
  endfunction

  // Mostly well-formed expressions with random operands, some broken ones
  task automatic send_random_line();
    int shape;
    int pick;
    int n_terms;
    longint unsigned num;
    shape = $urandom_range(99);
    if (shape < 4) begin
      // nothing kept before end of line
      repeat ($urandom_range(2)) send_req(CH_SPACE, 1'b0);
    end else if (shape < 7) begin
      // most negative value over minus one, both made by wrapping digits
      send_number(64'd2147483648);
      send_with_noise(alrc_pkg::CH_SLASH);
      send_number(64'd4294967295);
    end else begin
      if ($urandom_range(99) < 12) send_with_noise(random_operator());
      n_terms = $urandom_range(5, 1);
      for (int t = 0; t < n_terms; t++) begin
        if (t != 0) begin
          send_with_noise(random_operator());
          if ($urandom_range(99) < 4) send_with_noise(random_operator());
        end
        pick = $urandom_range(99);
        if (pick < 55)
          num = $urandom_range(99);
        else if (pick < 70)
          num = 0;
        else if (pick < 85)
          num = {$urandom, $urandom} % 64'd10000000000;
        else begin
          case ($urandom_range(3))
            0:       num = 64'd2147483647;
            1:       num = 64'd2147483648;
            2:       num = 64'd4294967295;
            default: num = 64'd65536;
          endcase
        end
        send_number(num);
      end
      if ($urandom_range(99) < 5) send_with_noise(random_operator());
    end
    send_req(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles less than receiver
    send_idle_pct  = 32;
    recv_stall_pct = 45;

    // Directed lines: empty, dropped extremes, leading operator with
    // truncating division, trailing operator, division by zero, operator
    // after operator, and characters ignored after an error
    send_req(8'h00, 1'b1);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(CH_SPACE, 1'b0);
    send_req(8'hFF, 1'b1);
    send_text("-7/2");
    send_text("3*4+");
    send_text("1/0");
    send_text("+*5");
    send_text("8/0+9");

    while (sent_items < 450) send_random_line();

    // Phase two: roles swapped
    send_idle_pct  = 45;
    recv_stall_pct = 32;
    while (sent_items < 900) send_random_line();

    // Phase three: full rate
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sent_items < 1350) send_random_line();

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (fail_count == 0 && results_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
